### sv/teb_pkg.sv
`timescale 1ns / 1ps

package teb_pkg;

  // Command codes carried on in_tuser
  typedef enum logic [2:0] {
    CMD_DEC    = 3'd0,
    CMD_EVEN   = 3'd1,
    CMD_CURSOR = 3'd2,
    CMD_COLOR  = 3'd3,
    CMD_VIS    = 3'd4
  } cmd_t;

  // Sequencer operations
  typedef enum logic [3:0] {
    OP_END,
    OP_LIT,
    OP_LOADA,
    OP_LOADB,
    OP_CONV,
    OP_SIGN,
    OP_PAD,
    OP_DIGITS,
    OP_TERM,
    OP_VIS
  } uop_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  // ASCII bytes used by the programs
  localparam logic [7:0] CH_NONE  = 8'h00;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_QUES  = 8'h3F;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_UPH   = 8'h48;
  localparam logic [7:0] CH_LOWM  = 8'h6D;
  localparam logic [7:0] CH_LOWH  = 8'h68;
  localparam logic [7:0] CH_LOWL  = 8'h6C;

  // Bytes per transaction are capped here
  localparam int RESULT_LIMIT = 16;
  localparam int BCNT_W       = $clog2(RESULT_LIMIT);

  // Program store
  localparam int UCODE_LEN = 24;
  localparam int PC_W      = $clog2(UCODE_LEN);

  localparam logic [PC_W-1:0] PC_END    = PC_W'(0);
  localparam logic [PC_W-1:0] PC_NUMBER = PC_W'(1);
  localparam logic [PC_W-1:0] PC_PAIR   = PC_W'(6);
  localparam logic [PC_W-1:0] PC_VIS    = PC_W'(18);

  typedef struct packed {
    uop_t       op;
    logic [7:0] chr;
    logic       last;
  } ucode_t;

  // Entry point of each command's program
  function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] cmd);
    logic [PC_W-1:0] pc;
    case (cmd)
      CMD_DEC, CMD_EVEN:    pc = PC_NUMBER;
      CMD_CURSOR, CMD_COLOR: pc = PC_PAIR;
      CMD_VIS:              pc = PC_VIS;
      default:              pc = PC_END;
    endcase
    return pc;
  endfunction

  // Control words, one per step
  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t cw;
    case (pc)
      // plain / even-padded decimal
      5'd1:    cw = '{op: OP_LOADA,  chr: CH_NONE,  last: 1'b0};
      5'd2:    cw = '{op: OP_CONV,   chr: CH_NONE,  last: 1'b0};
      5'd3:    cw = '{op: OP_SIGN,   chr: CH_MINUS, last: 1'b0};
      5'd4:    cw = '{op: OP_PAD,    chr: CH_ZERO,  last: 1'b0};
      5'd5:    cw = '{op: OP_DIGITS, chr: CH_ZERO,  last: 1'b1};
      // ESC [ a ; b H|m
      5'd6:    cw = '{op: OP_LIT,    chr: CH_ESC,   last: 1'b0};
      5'd7:    cw = '{op: OP_LIT,    chr: CH_LBRK,  last: 1'b0};
      5'd8:    cw = '{op: OP_LOADA,  chr: CH_NONE,  last: 1'b0};
      5'd9:    cw = '{op: OP_CONV,   chr: CH_NONE,  last: 1'b0};
      5'd10:   cw = '{op: OP_SIGN,   chr: CH_MINUS, last: 1'b0};
      5'd11:   cw = '{op: OP_DIGITS, chr: CH_ZERO,  last: 1'b0};
      5'd12:   cw = '{op: OP_LIT,    chr: CH_SEMI,  last: 1'b0};
      5'd13:   cw = '{op: OP_LOADB,  chr: CH_NONE,  last: 1'b0};
      5'd14:   cw = '{op: OP_CONV,   chr: CH_NONE,  last: 1'b0};
      5'd15:   cw = '{op: OP_SIGN,   chr: CH_MINUS, last: 1'b0};
      5'd16:   cw = '{op: OP_DIGITS, chr: CH_ZERO,  last: 1'b0};
      5'd17:   cw = '{op: OP_TERM,   chr: CH_NONE,  last: 1'b1};
      // ESC [ ? 2 5 h|l
      5'd18:   cw = '{op: OP_LIT,    chr: CH_ESC,   last: 1'b0};
      5'd19:   cw = '{op: OP_LIT,    chr: CH_LBRK,  last: 1'b0};
      5'd20:   cw = '{op: OP_LIT,    chr: CH_QUES,  last: 1'b0};
      5'd21:   cw = '{op: OP_LIT,    chr: CH_TWO,   last: 1'b0};
      5'd22:   cw = '{op: OP_LIT,    chr: CH_FIVE,  last: 1'b0};
      5'd23:   cw = '{op: OP_VIS,    chr: CH_NONE,  last: 1'b1};
      default: cw = '{op: OP_END,    chr: CH_NONE,  last: 1'b0};
    endcase
    return cw;
  endfunction

endpackage

### sv/terminal_escape_sequence_builder_unit.sv
`timescale 1ns / 1ps

// Channel | Dir | Handshake            | Payload
// in_     | in  | in_tvalid/in_tready  | tuser: command; tdata: first, second, hide
// out_    | out | out_tvalid/out_tready| tdata: out_char; tlast: last_char
//
// One command at a time. A number costs a load step, then per decimal digit a
// reciprocal multiply followed by a remainder step, then one step per emitted
// byte; each literal byte is one step as well.
// The divide-by-ten multiplier and the single output register set the pace.
// Reset (rst_n low, synchronous) clears the sequencer and output valid.
// A stalled output register holds the sequencer; input is taken only when idle.

module terminal_escape_sequence_builder_unit #(
  parameter int MAX_DIGITS   = 5,
  parameter int NUMBER_WIDTH = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // [NW-1:0] first_number, [2NW-1:NW] second_number, [2NW] hide_flag
  input  logic [((2*NUMBER_WIDTH+1+7)/8)*8-1:0]      in_tdata,
  // [2:0] command
  input  logic [2:0]                                 in_tuser,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  // [7:0] out_char
  output logic [7:0]                                 out_tdata,
  output logic                                       out_tlast
);

  localparam int NW    = NUMBER_WIDTH;
  localparam int PW    = 2 * NW + 1;
  localparam int QSH   = NW + 3;
  localparam int CNTW  = $clog2(MAX_DIGITS + 1);
  localparam int IDXW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int PC_W  = teb_pkg::PC_W;
  localparam int BW    = teb_pkg::BCNT_W;
  // floor(x/10) == (x*RECIP) >> QSH for every x below 2**NW
  localparam logic [NW:0] RECIP = (NW+1)'(((64'd1 << QSH) + 64'd9) / 64'd10);

  // Control registers
  teb_pkg::seq_state_t state_r, state_nxt;
  logic [PC_W-1:0]     pc_r;
  logic                out_valid_r;
  logic [BW-1:0]       cnt_r;
  logic [CNTW-1:0]     n_r;
  logic [CNTW-1:0]     idx_r;
  logic                conv_ph_r;

  // Payload registers
  logic [2:0]          cmd_r;
  logic [NW-1:0]       a_r;
  logic [NW-1:0]       b_r;
  logic                hide_r;
  logic                neg_r;
  logic [NW-1:0]       mag_r;
  logic [PW-1:0]       prod_r;
  logic [3:0]          dbuf_r [MAX_DIGITS];
  logic [7:0]          out_data_r;
  logic                out_last_r;

  // Decode and datapath signals
  teb_pkg::ucode_t     cw;
  logic                in_go;
  logic                out_free;
  logic                emit;
  logic                emit_go;
  logic                emit_last;
  logic [7:0]          emit_char;
  logic                advance;
  logic                finish;
  logic [NW-1:0]       load_v;
  logic [NW-1:0]       load_mag;
  logic [NW-1:0]       q;
  logic [NW-1:0]       rem;
  logic                conv_stop;
  logic [CNTW-1:0]     idx_m1;
  logic [IDXW-1:0]     rd_idx;

  assign cw     = teb_pkg::ucode(pc_r);
  assign in_go  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Operand load and divide-by-ten step
  assign load_v    = (cw.op == teb_pkg::OP_LOADB) ? b_r : a_r;
  assign load_mag  = load_v[NW-1] ? (~load_v + NW'(1)) : load_v;
  assign q         = NW'(prod_r >> QSH);
  assign rem       = mag_r - (q << 3) - (q << 1);
  assign conv_stop = (q == '0) || (n_r == CNTW'(MAX_DIGITS - 1));
  assign idx_m1    = idx_r - CNTW'(1);
  assign rd_idx    = idx_m1[IDXW-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      teb_pkg::ST_IDLE: if (in_tvalid) state_nxt = teb_pkg::ST_RUN;
      teb_pkg::ST_RUN:  if (finish) state_nxt = teb_pkg::ST_IDLE;
      default:          state_nxt = teb_pkg::ST_IDLE;
    endcase
  end

  // Step decode: what the current control word emits and whether it advances
  always_comb begin
    in_tready = (state_r == teb_pkg::ST_IDLE);
    emit      = 1'b0;
    emit_char = cw.chr;
    advance   = 1'b0;
    finish    = 1'b0;
    if (state_r == teb_pkg::ST_RUN) begin
      case (cw.op)
        teb_pkg::OP_END:    finish = 1'b1;
        teb_pkg::OP_LIT: begin
          emit    = 1'b1;
          advance = 1'b1;
        end
        teb_pkg::OP_LOADA,
        teb_pkg::OP_LOADB:  advance = 1'b1;
        teb_pkg::OP_CONV:   advance = conv_ph_r && conv_stop;
        teb_pkg::OP_SIGN: begin
          emit    = neg_r;
          advance = 1'b1;
        end
        teb_pkg::OP_PAD: begin
          emit    = (cmd_r == teb_pkg::CMD_EVEN) && n_r[0];
          advance = 1'b1;
        end
        teb_pkg::OP_DIGITS: begin
          emit      = 1'b1;
          emit_char = teb_pkg::CH_ZERO + {4'b0000, dbuf_r[rd_idx]};
          advance   = (idx_r == CNTW'(1));
        end
        teb_pkg::OP_TERM: begin
          emit      = 1'b1;
          emit_char = (cmd_r == teb_pkg::CMD_CURSOR) ? teb_pkg::CH_UPH : teb_pkg::CH_LOWM;
          advance   = 1'b1;
        end
        teb_pkg::OP_VIS: begin
          emit      = 1'b1;
          emit_char = hide_r ? teb_pkg::CH_LOWL : teb_pkg::CH_LOWH;
          advance   = 1'b1;
        end
        default:            finish = 1'b1;
      endcase
    end
    // hold the step while the output register is occupied
    if (emit && !out_free) advance = 1'b0;
    emit_go   = emit && out_free;
    emit_last = (cw.last && advance) || (cnt_r == BW'(teb_pkg::RESULT_LIMIT - 1));
    if (emit_go && emit_last) finish = 1'b1;
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= teb_pkg::ST_IDLE;
      pc_r        <= teb_pkg::PC_END;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      n_r         <= '0;
      idx_r       <= '0;
      conv_ph_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (in_go) begin
        pc_r  <= teb_pkg::entry_pc(in_tuser);
        cnt_r <= '0;
      end else if (state_r == teb_pkg::ST_RUN) begin
        if (emit_go) cnt_r <= cnt_r + BW'(1);
        if (advance) pc_r <= pc_r + PC_W'(1);
        case (cw.op)
          teb_pkg::OP_LOADA,
          teb_pkg::OP_LOADB: begin
            n_r       <= '0;
            conv_ph_r <= 1'b0;
          end
          teb_pkg::OP_CONV: begin
            conv_ph_r <= !conv_ph_r;
            if (conv_ph_r) begin
              n_r <= n_r + CNTW'(1);
              if (conv_stop) idx_r <= n_r + CNTW'(1);
            end
          end
          teb_pkg::OP_DIGITS: if (emit_go) idx_r <= idx_m1;
          default: ;
        endcase
      end
    end
  end

  // Item latch, digit store and output data
  always_ff @(posedge clk) begin
    if (in_go) begin
      cmd_r  <= in_tuser;
      a_r    <= in_tdata[NW-1:0];
      b_r    <= in_tdata[2*NW-1:NW];
      hide_r <= in_tdata[2*NW];
    end
    if (state_r == teb_pkg::ST_RUN) begin
      case (cw.op)
        teb_pkg::OP_LOADA,
        teb_pkg::OP_LOADB: begin
          neg_r <= load_v[NW-1];
          mag_r <= load_mag;
        end
        teb_pkg::OP_CONV: begin
          if (!conv_ph_r) begin
            prod_r <= PW'(mag_r) * PW'(RECIP);
          end else begin
            dbuf_r[n_r[IDXW-1:0]] <= rem[3:0];
            mag_r <= q;
          end
        end
        default: ;
      endcase
    end
    if (emit_go) begin
      out_data_r <= emit_char;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Checks
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && emit_last) |=> (state_r == teb_pkg::ST_IDLE))
    else $error("sequencer still running after final byte");

  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_go |=> (state_r == teb_pkg::ST_RUN) && (cnt_r == '0))
    else $error("transaction did not start a fresh program");

  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNTW'(MAX_DIGITS))
    else $error("digit count beyond store depth");

  a_digit_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == teb_pkg::ST_RUN && cw.op == teb_pkg::OP_DIGITS)
      |-> (idx_r != '0) && (idx_r <= n_r))
    else $error("digit read outside converted range");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int TDATA_W = 40;

  // Command codes the block ignores
  localparam logic [2:0] CMD_SPARE5 = 3'd5;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  localparam int ITEMS_PER_PHASE = 47;
  localparam int LONG_STALL      = 300;
  localparam int DRAIN_CYCLES    = 80;

  // Holds the text bytes still owed by the block, oldest first
  class escape_text_scoreboard;
    logic [7:0] pending_chars[$];
    logic       pending_last[$];
    logic [7:0] text[$];
    int         error_count = 0;

    // Signed decimal with optional zero pad to an even digit count
    function void add_number(logic [15:0] value, bit even_pad);
      logic [16:0] mag;
      logic [3:0]  digits[5];
      int          n;
      mag = value[15] ? ({1'b0, ~value} + 17'd1) : {1'b0, value};
      n = 0;
      if (mag == 0) begin
        digits[0] = 4'd0;
        n = 1;
      end else begin
        while (mag != 0 && n < 5) begin
          digits[n] = 4'(mag % 10);
          mag = mag / 10;
          n++;
        end
      end
      if (value[15]) text.push_back(teb_pkg::CH_MINUS);
      if (even_pad && n[0]) text.push_back(teb_pkg::CH_ZERO);
      for (int k = n - 1; k >= 0; k--)
        text.push_back(teb_pkg::CH_ZERO + 8'(digits[k]));
    endfunction

    function void note_command(logic [2:0] cmd, logic [15:0] first, logic [15:0] second,
                               logic hide);
      int n;
      text.delete();
      case (cmd)
        teb_pkg::CMD_DEC:  add_number(first, 1'b0);
        teb_pkg::CMD_EVEN: add_number(first, 1'b1);
        teb_pkg::CMD_CURSOR, teb_pkg::CMD_COLOR: begin
          text.push_back(teb_pkg::CH_ESC);
          text.push_back(teb_pkg::CH_LBRK);
          add_number(first, 1'b0);
          text.push_back(teb_pkg::CH_SEMI);
          add_number(second, 1'b0);
          text.push_back((cmd == teb_pkg::CMD_CURSOR) ? teb_pkg::CH_UPH
                                                      : teb_pkg::CH_LOWM);
        end
        teb_pkg::CMD_VIS: begin
          text.push_back(teb_pkg::CH_ESC);
          text.push_back(teb_pkg::CH_LBRK);
          text.push_back(teb_pkg::CH_QUES);
          text.push_back(teb_pkg::CH_TWO);
          text.push_back(teb_pkg::CH_FIVE);
          text.push_back(hide ? teb_pkg::CH_LOWL : teb_pkg::CH_LOWH);
        end
        default: ;
      endcase
      n = (text.size() > teb_pkg::RESULT_LIMIT) ? teb_pkg::RESULT_LIMIT : text.size();
      for (int k = 0; k < n; k++) begin
        pending_chars.push_back(text[k]);
        pending_last.push_back(k == n - 1);
      end
    endfunction

    function void check_char(logic [7:0] got_char, logic got_last);
      logic [7:0] exp_char;
      logic       exp_last;
      if (pending_chars.size() == 0) begin
        $error("unexpected output transaction: out_char=%02h out_tlast=%0b", got_char,
               got_last);
        error_count++;
        return;
      end
      exp_char = pending_chars.pop_front();
      exp_last = pending_last.pop_front();
      if (got_char !== exp_char) begin
        $error("out_char mismatch: expected %02h actual %02h", exp_char, got_char);
        error_count++;
      end
      if (got_last !== exp_last) begin
        $error("last_char mismatch: expected %0b actual %0b", exp_last, got_last);
        error_count++;
      end
    endfunction

    function int outstanding();
      return pending_chars.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata   = '0;
  logic [2:0]         in_tuser   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [7:0]         out_tdata;
  logic               out_tlast;

  int tx_idle_pct    = 0;
  int rx_idle_pct    = 0;
  bit long_stall_req = 1'b0;

  escape_text_scoreboard text_sb = new();

  terminal_escape_sequence_builder_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("terminal_escape_sequence_builder_unit verification failed");
    $finish;
  end

  // Transaction monitors, sampled on the clock edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      text_sb.note_command(in_tuser, in_tdata[15:0], in_tdata[31:16], in_tdata[32]);
    if (rst_n && out_tvalid && out_tready)
      text_sb.check_char(out_tdata, out_tlast);
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        repeat (LONG_STALL) begin
          out_tready <= 1'b0;
          @(posedge clk);
        end
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one command and hold it until the block takes it
  task automatic send_command(logic [2:0] cmd, logic [15:0] first, logic [15:0] second,
                              logic hide);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'b0, hide, second, first};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Mix of short numbers, wide random values and the range ends
  function automatic logic [15:0] pick_number();
    int          mag;
    logic [15:0] v;
    case ($urandom_range(3))
      0: mag = $urandom_range(9);
      1: mag = $urandom_range(9999);
      2: return 16'($urandom);
      default: begin
        case ($urandom_range(3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
    endcase
    v = 16'(mag);
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  task automatic run_random_phase(int tx_pct, int rx_pct);
    int          done;
    logic [2:0]  cmd;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    done = 0;
    while (done < ITEMS_PER_PHASE) begin
      if ($urandom_range(99) < 8)
        cmd = 3'($urandom_range(CMD_SPARE7, CMD_SPARE5));
      else
        cmd = 3'($urandom_range(teb_pkg::CMD_VIS, teb_pkg::CMD_DEC));
      send_command(cmd, pick_number(), pick_number(), 1'($urandom_range(1)));
      if (cmd <= teb_pkg::CMD_VIS) done++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 17;
    rx_idle_pct = 86;
    @(posedge clk);

    // Directed: range ends, zero, padding, every command, ignored codes
    send_command(teb_pkg::CMD_DEC,    16'h0000, 16'h0000, 1'b0);
    send_command(teb_pkg::CMD_DEC,    16'h8000, 16'h0000, 1'b0);
    send_command(teb_pkg::CMD_DEC,    16'h7FFF, 16'h0000, 1'b0);
    send_command(teb_pkg::CMD_DEC,    16'hFFFF, 16'h0000, 1'b0);
    send_command(teb_pkg::CMD_DEC,    16'd7,    16'h0000, 1'b0);
    send_command(teb_pkg::CMD_EVEN,   16'h0000, 16'h0000, 1'b0);
    send_command(teb_pkg::CMD_EVEN,   16'h8000, 16'h0000, 1'b0);
    send_command(teb_pkg::CMD_EVEN,   16'd1234, 16'h0000, 1'b0);
    send_command(teb_pkg::CMD_EVEN,   -16'sd5,  16'h0000, 1'b0);
    send_command(teb_pkg::CMD_EVEN,   16'h7FFF, 16'h0000, 1'b0);
    send_command(teb_pkg::CMD_CURSOR, 16'h8000, 16'h8000, 1'b0);
    send_command(teb_pkg::CMD_CURSOR, 16'h0000, 16'h7FFF, 1'b0);
    send_command(teb_pkg::CMD_CURSOR, 16'd1,    16'hFFFF, 1'b0);
    send_command(teb_pkg::CMD_COLOR,  16'd40,   16'd37,   1'b0);
    send_command(teb_pkg::CMD_COLOR,  16'h8000, 16'h0000, 1'b1);
    send_command(teb_pkg::CMD_VIS,    16'hFFFF, 16'hFFFF, 1'b0);
    send_command(teb_pkg::CMD_VIS,    16'h0000, 16'h0000, 1'b1);
    send_command(CMD_SPARE5,          16'h5555, 16'hAAAA, 1'b1);
    send_command(CMD_SPARE6,          16'hAAAA, 16'h5555, 1'b0);
    send_command(CMD_SPARE7,          16'hFFFF, 16'hFFFF, 1'b1);

    run_random_phase(17, 86);
    run_random_phase(86, 17);
    // Full-rate sender against a receiver that holds off for a while
    long_stall_req = 1'b1;
    run_random_phase(0, 0);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (text_sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (text_sb.error_count == 0)
      $display("terminal_escape_sequence_builder_unit verification clean");
    else
      $display("terminal_escape_sequence_builder_unit verification failed");
    $finish;
  end

endmodule

### files.f
sv/teb_pkg.sv
sv/terminal_escape_sequence_builder_unit.sv
sim/tb_top.sv
